@@ hw/rtl/bfx_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bfx_pkg;

  localparam int unsigned ADDR_W = 16;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned SKIP_W = 16;

  localparam int unsigned TAPE_DEPTH_DEF   = 16384;
  localparam int unsigned STACK_DEPTH_DEF  = 64;
  localparam int unsigned ADDRESS_BITS_DEF = 16;

  // program characters
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_LT    = 8'h3C;
  localparam logic [BYTE_W-1:0] CH_GT    = 8'h3E;
  localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h5D;
  localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;

  localparam logic CMD_START = 1'b0;

  typedef enum logic [3:0] {
    OP_START,
    OP_INC,
    OP_DEC,
    OP_LEFT,
    OP_RIGHT,
    OP_OPEN,
    OP_CLOSE,
    OP_DOT,
    OP_NOP
  } op_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_OVERFLOW = 2'd1,
    ERR_EMPTY    = 2'd2
  } err_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } bk_state_e;

  typedef struct packed {
    op_e               op;
    logic [ADDR_W-1:0] next_addr;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

  typedef struct packed {
    logic take;
    logic clearing;
  } bk_status_t;

  function automatic op_e decode_op(input logic cmd, input logic [BYTE_W-1:0] code);
    op_e op;
    op = OP_NOP;
    if (cmd == CMD_START) begin
      op = OP_START;
    end else begin
      unique case (code)
        CH_PLUS:  op = OP_INC;
        CH_MINUS: op = OP_DEC;
        CH_LT:    op = OP_LEFT;
        CH_GT:    op = OP_RIGHT;
        CH_OPEN:  op = OP_OPEN;
        CH_CLOSE: op = OP_CLOSE;
        CH_DOT:   op = OP_DOT;
        default:  op = OP_NOP;
      endcase
    end
    return op;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/bfx_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bfx_front #(
  parameter int unsigned ADDRESS_BITS = bfx_pkg::ADDRESS_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cmd_valid_i,
  output logic                             cmd_stall_o,
  input  wire logic                        command_i,
  input  wire logic [bfx_pkg::BYTE_W-1:0]  code_byte_i,
  input  wire logic [bfx_pkg::ADDR_W-1:0]  code_address_i,
  output bfx_pkg::q_head_t                 head_o,
  input  wire bfx_pkg::bk_status_t         status_i
);
  import bfx_pkg::*;

  localparam int unsigned AddrW = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
  localparam logic [ADDR_W-1:0] AddrMask = ADDR_W'((64'd1 << AddrW) - 64'd1);

  q_entry_t   q_mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  q_entry_t   new_entry;

  // classify the request and form the sequential fetch address
  always_comb begin
    new_entry.op        = decode_op(command_i, code_byte_i);
    new_entry.next_addr = (code_address_i + 1'b1) & AddrMask;
  end

  assign cmd_stall_o = (cnt_q == 2'd2) || status_i.clearing;
  assign push        = cmd_valid_i && !cmd_stall_o;
  assign pop         = status_i.take && (cnt_q != 2'd0);

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= new_entry;
    end
  end

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.entry = q_mem_q[rd_ptr_q];

endmodule

`default_nettype wire

@@ hw/rtl/bfx_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bfx_back #(
  parameter int unsigned TAPE_DEPTH  = bfx_pkg::TAPE_DEPTH_DEF,
  parameter int unsigned STACK_DEPTH = bfx_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire bfx_pkg::q_head_t            head_i,
  output bfx_pkg::bk_status_t              status_o,
  output logic                             res_valid_o,
  input  wire logic                        res_stall_i,
  output logic [bfx_pkg::ADDR_W-1:0]       next_address_o,
  output logic                             out_valid_o,
  output logic [bfx_pkg::BYTE_W-1:0]       out_byte_o,
  output logic                             skipping_o,
  output logic [1:0]                       error_o
);
  import bfx_pkg::*;

  localparam int unsigned TPW = $clog2(TAPE_DEPTH);
  localparam int unsigned SIW = $clog2(STACK_DEPTH);
  localparam int unsigned SCW = $clog2(STACK_DEPTH + 1);
  localparam logic [TPW-1:0]    TapeLast  = TPW'(TAPE_DEPTH - 1);
  localparam logic [SCW-1:0]    StackFull = SCW'(STACK_DEPTH);
  localparam logic [SKIP_W-1:0] SkipMax   = '1;

  logic [BYTE_W-1:0] tape_mem [TAPE_DEPTH];
  logic [ADDR_W-1:0] stk_mem  [STACK_DEPTH];

  bk_state_e         state_q, state_d;
  op_e               op_q, op_d;
  logic [ADDR_W-1:0] nxt_q, nxt_d;
  logic [TPW-1:0]    dp_q, dp_d;
  logic [TPW-1:0]    clr_q, clr_d;
  logic [SCW-1:0]    cnt_q, cnt_d;
  logic [SKIP_W-1:0] sdepth_q, sdepth_d;
  logic              skip_q, skip_d;
  logic [BYTE_W-1:0] cell_q;
  logic [ADDR_W-1:0] top_q;

  logic              res_valid_q, res_valid_d;
  logic [ADDR_W-1:0] r_next_q, r_next_d;
  logic              r_ov_q, r_ov_d;
  logic [BYTE_W-1:0] r_byte_q, r_byte_d;
  logic              r_skip_q, r_skip_d;
  err_e              r_err_q, r_err_d;

  logic              out_free, take, exec_fire;
  logic              tape_we, tape_re, stk_we, stk_re;
  logic [TPW-1:0]    tape_waddr;
  logic [BYTE_W-1:0] tape_wdata;

  assign out_free = !res_valid_q || !res_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == TapeLast) begin
          state_d = (op_q == OP_START) ? ST_EXEC : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (head_i.valid) begin
          state_d = (head_i.entry.op == OP_START) ? ST_CLEAR : ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // state outputs
  always_comb begin
    take              = 1'b0;
    exec_fire         = 1'b0;
    status_o.clearing = 1'b0;
    unique case (state_q)
      ST_CLEAR: status_o.clearing = 1'b1;
      ST_IDLE:  take = head_i.valid;
      ST_EXEC:  exec_fire = out_free;
      default:  take = 1'b0;
    endcase
    status_o.take = take;
    tape_re       = take;
    stk_re        = take;
  end

  // execute datapath
  always_comb begin
    op_d        = op_q;
    nxt_d       = nxt_q;
    dp_d        = dp_q;
    clr_d       = clr_q;
    cnt_d       = cnt_q;
    sdepth_d    = sdepth_q;
    skip_d      = skip_q;
    tape_we     = 1'b0;
    tape_waddr  = dp_q;
    tape_wdata  = cell_q;
    stk_we      = 1'b0;
    res_valid_d = res_valid_q && res_stall_i;
    r_next_d    = r_next_q;
    r_ov_d      = r_ov_q;
    r_byte_d    = r_byte_q;
    r_skip_d    = r_skip_q;
    r_err_d     = r_err_q;

    if (take) begin
      op_d  = head_i.entry.op;
      nxt_d = head_i.entry.next_addr;
      clr_d = '0;
    end

    if (state_q == ST_CLEAR) begin
      tape_we    = 1'b1;
      tape_waddr = clr_q;
      tape_wdata = '0;
      clr_d      = clr_q + 1'b1;
    end

    if (exec_fire) begin
      r_next_d = nxt_q;
      r_ov_d   = 1'b0;
      r_byte_d = '0;
      r_err_d  = ERR_NONE;
      if (op_q == OP_START) begin
        skip_d   = 1'b0;
        sdepth_d = '0;
        r_next_d = '0;
      end else if (skip_q) begin
        case (op_q)
          OP_OPEN: begin
            if (sdepth_q != SkipMax) begin
              sdepth_d = sdepth_q + 1'b1;
            end
          end
          OP_CLOSE: begin
            if (sdepth_q != '0) begin
              sdepth_d = sdepth_q - 1'b1;
            end else begin
              skip_d = 1'b0;
            end
          end
          default: skip_d = skip_q;
        endcase
      end else begin
        case (op_q)
          OP_INC: begin
            tape_we    = 1'b1;
            tape_wdata = cell_q + 1'b1;
          end
          OP_DEC: begin
            tape_we    = 1'b1;
            tape_wdata = cell_q - 1'b1;
          end
          OP_LEFT:  dp_d = (dp_q == '0) ? TapeLast : dp_q - 1'b1;
          OP_RIGHT: dp_d = (dp_q == TapeLast) ? '0 : dp_q + 1'b1;
          OP_OPEN: begin
            if (cell_q == '0) begin
              skip_d   = 1'b1;
              sdepth_d = '0;
            end else if (cnt_q == StackFull) begin
              r_err_d = ERR_OVERFLOW;
            end else begin
              stk_we = 1'b1;
              cnt_d  = cnt_q + 1'b1;
            end
          end
          OP_CLOSE: begin
            if (cnt_q == '0) begin
              r_err_d = ERR_EMPTY;
            end else if (cell_q == '0) begin
              cnt_d = cnt_q - 1'b1;
            end else begin
              r_next_d = top_q;
            end
          end
          OP_DOT: begin
            r_ov_d   = 1'b1;
            r_byte_d = cell_q;
          end
          default: r_ov_d = 1'b0;
        endcase
      end
      r_skip_d    = skip_d;
      res_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      op_q        <= OP_NOP;
      clr_q       <= '0;
      dp_q        <= '0;
      cnt_q       <= '0;
      sdepth_q    <= '0;
      skip_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      clr_q       <= clr_d;
      dp_q        <= dp_d;
      cnt_q       <= cnt_d;
      sdepth_q    <= sdepth_d;
      skip_q      <= skip_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nxt_q    <= nxt_d;
    r_next_q <= r_next_d;
    r_ov_q   <= r_ov_d;
    r_byte_q <= r_byte_d;
    r_skip_q <= r_skip_d;
    r_err_q  <= r_err_d;
  end

  // tape memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (tape_we) begin
      tape_mem[tape_waddr] <= tape_wdata;
    end
    if (tape_re) begin
      cell_q <= tape_mem[dp_q];
    end
  end

  // loop stack memory, top entry read ahead of execution
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[cnt_q[SIW-1:0]] <= nxt_q;
    end
    if (stk_re) begin
      top_q <= stk_mem[SIW'(cnt_q - 1'b1)];
    end
  end

  assign res_valid_o    = res_valid_q;
  assign next_address_o = r_next_q;
  assign out_valid_o    = r_ov_q;
  assign out_byte_o     = r_byte_q;
  assign skipping_o     = r_skip_q;
  assign error_o        = r_err_q;

endmodule

`default_nettype wire

@@ hw/rtl/bf_instruction_executor_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// program byte executor: each request carries one fetched program byte and its address (or a
// start command) and yields one result with the next fetch address, an optional output byte,
// the skip flag and an error code. in the back end a plain program byte is first taken in
// the idle state, which reads the current tape cell and the loop stack top from synchronous
// memory; then the execute state modifies, writes back and loads the result register once
// that register is free, and the back end takes no new request before that. a start
// command runs a clearing pass over the whole tape before its result; after reset the same
// pass runs before any request is taken, and cmd_stall_o stays high while it runs. a 2-entry
// queue sits between the decoding front end and the back end, and the result register frees
// the back end as soon as a held result is taken, so while a result waits up to three more
// requests can be taken: one held in the back end and two in the queue.
module bf_instruction_executor_unit #(
  parameter int unsigned TAPE_DEPTH   = bfx_pkg::TAPE_DEPTH_DEF,
  parameter int unsigned STACK_DEPTH  = bfx_pkg::STACK_DEPTH_DEF,
  parameter int unsigned ADDRESS_BITS = bfx_pkg::ADDRESS_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // request channel
  input  wire logic                        cmd_valid_i,
  output logic                             cmd_stall_o,
  input  wire logic                        command_i,
  input  wire logic [bfx_pkg::BYTE_W-1:0]  code_byte_i,
  input  wire logic [bfx_pkg::ADDR_W-1:0]  code_address_i,
  // result channel
  output logic                             res_valid_o,
  input  wire logic                        res_stall_i,
  output logic [bfx_pkg::ADDR_W-1:0]       next_address_o,
  output logic                             out_valid_o,
  output logic [bfx_pkg::BYTE_W-1:0]       out_byte_o,
  output logic                             skipping_o,
  output logic [1:0]                       error_o
);
  import bfx_pkg::*;

  q_head_t    head;
  bk_status_t status;

  // front end: decode into an op code, precompute address + 1, queue it
  bfx_front #(
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .cmd_valid_i,
    .cmd_stall_o,
    .command_i,
    .code_byte_i,
    .code_address_i,
    .head_o   (head),
    .status_i (status)
  );

  // back end: tape, pointer, loop stack, skip tracking and result register
  bfx_back #(
    .TAPE_DEPTH (TAPE_DEPTH),
    .STACK_DEPTH(STACK_DEPTH)
  ) u_back (
    .clk_i,
    .rst_ni,
    .head_i   (head),
    .status_o (status),
    .res_valid_o,
    .res_stall_i,
    .next_address_o,
    .out_valid_o,
    .out_byte_o,
    .skipping_o,
    .error_o
  );

endmodule

`default_nettype wire

@@ hw/rtl/bfx_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bfx_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        cmd_valid_i,
  input wire logic        cmd_stall_o,
  input wire logic        command_i,
  input wire logic [7:0]  code_byte_i,
  input wire logic [15:0] code_address_i,
  input wire logic        res_valid_o,
  input wire logic        res_stall_i,
  input wire logic [15:0] next_address_o,
  input wire logic        out_valid_o,
  input wire logic [7:0]  out_byte_o,
  input wire logic        skipping_o,
  input wire logic [1:0]  error_o
);
  import bfx_pkg::*;

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_stall_i |=> res_valid_o && $stable(next_address_o)
      && $stable(out_valid_o) && $stable(out_byte_o) && $stable(skipping_o)
      && $stable(error_o))
    else $error("result changed while stalled");

  // an output byte never comes with an error or in skip mode
  a_dot_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && out_valid_o |-> error_o == ERR_NONE && !skipping_o)
    else $error("output byte with error or skip");

  // no output byte without a dot, and errors never carry one
  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (!out_valid_o || error_o != ERR_NONE) |-> out_byte_o == '0)
    else $error("stray output byte");

  // the tape clearing pass after reset holds off requests
  a_reset_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> cmd_stall_o && !res_valid_o)
    else $error("request taken during reset clearing");

endmodule

bind bf_instruction_executor_unit bfx_checker u_bfx_checker (.*);

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import bfx_pkg::*;

  // sizes of the block as built with its default parameters
  localparam int TAPE_N = TAPE_DEPTH_DEF;
  localparam int STACK_N = STACK_DEPTH_DEF;
  localparam logic CMD_EXEC = ~CMD_START;

  // random part length, counted in requests that do something
  localparam int RAND_ITEMS = 1000;
  // closing stretch: enter skip, nest TAIL_OPENS brackets deep, then walk
  // back down and leave skip on the last ']'
  localparam int TAIL_OPENS = 20;
  localparam int TAIL_CLOSES = 21;
  localparam int CYCLE_LIMIT = 2_500_000;
  localparam int DIR_N = 25;

  localparam logic [7:0] OP_CHARS [7] = '{CH_PLUS, CH_MINUS, CH_LT, CH_GT, CH_DOT,
                                          CH_OPEN, CH_CLOSE};

  typedef struct packed {
    logic [15:0] nxt;
    logic        ov;
    logic [7:0]  ob;
    logic        sk;
    err_e        er;
  } res_t;

  typedef struct {
    logic        cmd;
    logic [7:0]  b;
    logic [15:0] a;
    bit          typed;
    res_t        want;
  } dir_row_t;

  typedef enum int {PH_TABLE, PH_RANDOM, PH_TAIL, PH_DONE} phase_e;
  typedef enum int {GM_PROG, GM_PUSH, GM_POP, GM_NOISE} gen_mode_e;

  localparam res_t NO_RES = '0;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // request side
  logic        cmd_valid = 1'b0;
  logic        cmd_stall_o;
  logic        command = CMD_EXEC;
  logic [7:0]  code_byte = 8'h00;
  logic [15:0] code_address = 16'h0000;

  // result side
  logic        res_valid_o;
  logic        res_stall = 1'b0;
  logic [15:0] next_address_o;
  logic        out_valid_o;
  logic [7:0]  out_byte_o;
  logic        skipping_o;
  logic [1:0]  error_o;

  always #2 clk = ~clk;

  bf_instruction_executor_unit dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cmd_valid_i   (cmd_valid),
    .cmd_stall_o   (cmd_stall_o),
    .command_i     (command),
    .code_byte_i   (code_byte),
    .code_address_i(code_address),
    .res_valid_o   (res_valid_o),
    .res_stall_i   (res_stall),
    .next_address_o(next_address_o),
    .out_valid_o   (out_valid_o),
    .out_byte_o    (out_byte_o),
    .skipping_o    (skipping_o),
    .error_o       (error_o)
  );

  // ---------------------------------------------------------------------------
  // interpreter state mirror, as after reset
  // ---------------------------------------------------------------------------
  logic [7:0]  tape_mem [TAPE_N] = '{default: 8'h00};
  int          dptr = 0;
  logic [15:0] ret_stack [STACK_N] = '{default: 16'h0000};
  int          ret_count = 0;
  logic [15:0] skip_lvl = 16'h0000;
  bit          skip_on = 1'b0;

  res_t expected_q [$];
  int   fail_count = 0;

  // runs one request through the mirror and returns the result it must give
  function automatic res_t execute_step(input logic cmd, input logic [7:0] b,
                                        input logic [15:0] a);
    res_t r;
    logic [7:0] cur_cell;
    r.nxt = a + 16'd1;
    r.ov = 1'b0;
    r.ob = 8'h00;
    r.sk = 1'b0;
    r.er = ERR_NONE;
    cur_cell = tape_mem[dptr];
    if (cmd == CMD_START) begin
      // tape and skip cleared, pointer and return stack survive
      foreach (tape_mem[i]) tape_mem[i] = 8'h00;
      skip_on = 1'b0;
      skip_lvl = 16'h0000;
      r.nxt = 16'h0000;
    end else if (skip_on) begin
      // only brackets count while skipping a loop body
      if (b == CH_OPEN) begin
        if (skip_lvl != 16'hFFFF) skip_lvl = skip_lvl + 16'd1;
      end else if (b == CH_CLOSE) begin
        if (skip_lvl != 16'h0000) skip_lvl = skip_lvl - 16'd1;
        else skip_on = 1'b0;
      end
    end else begin
      case (b)
        CH_PLUS:  tape_mem[dptr] = cur_cell + 8'd1;
        CH_MINUS: tape_mem[dptr] = cur_cell - 8'd1;
        CH_LT:    dptr = (dptr == 0) ? TAPE_N - 1 : dptr - 1;
        CH_GT:    dptr = (dptr == TAPE_N - 1) ? 0 : dptr + 1;
        CH_OPEN: begin
          if (cur_cell == 8'h00) begin
            skip_on = 1'b1;
            skip_lvl = 16'h0000;
          end else if (ret_count >= STACK_N) begin
            r.er = ERR_OVERFLOW;
          end else begin
            ret_stack[ret_count] = r.nxt;
            ret_count++;
          end
        end
        CH_CLOSE: begin
          if (ret_count == 0) r.er = ERR_EMPTY;
          else if (cur_cell == 8'h00) ret_count--;
          else r.nxt = ret_stack[ret_count - 1];
        end
        CH_DOT: begin
          r.ov = 1'b1;
          r.ob = cur_cell;
        end
        default: ;
      endcase
    end
    r.sk = skip_on;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // directed requests; typed results only where they are obvious
  // ---------------------------------------------------------------------------
  dir_row_t dir_tab [DIR_N];

  initial begin
    dir_tab = '{
      // output of a fresh cell
      '{CMD_EXEC, CH_DOT,   16'h0000, 1'b1, '{16'h0001, 1'b1, 8'h00, 1'b0, ERR_NONE}},
      // decrement wraps the cell to 0xff, top address wraps to zero
      '{CMD_EXEC, CH_MINUS, 16'hFFFF, 1'b1, '{16'h0000, 1'b0, 8'h00, 1'b0, ERR_NONE}},
      '{CMD_EXEC, CH_DOT,   16'h1234, 1'b1, '{16'h1235, 1'b1, 8'hFF, 1'b0, ERR_NONE}},
      // increment wraps back to zero
      '{CMD_EXEC, CH_PLUS,  16'h0002, 1'b1, '{16'h0003, 1'b0, 8'h00, 1'b0, ERR_NONE}},
      // pop on an empty stack
      '{CMD_EXEC, CH_CLOSE, 16'h0010, 1'b1, '{16'h0011, 1'b0, 8'h00, 1'b0, ERR_EMPTY}},
      // pointer wraps below zero and above the top
      '{CMD_EXEC, CH_LT,    16'h0020, 1'b0, NO_RES},
      '{CMD_EXEC, CH_PLUS,  16'h0021, 1'b0, NO_RES},
      '{CMD_EXEC, CH_GT,    16'h0022, 1'b0, NO_RES},
      '{CMD_EXEC, CH_LT,    16'h0023, 1'b0, NO_RES},
      // loop entry on a nonzero cell, jump back, then exit with a pop
      '{CMD_EXEC, CH_OPEN,  16'h0100, 1'b0, NO_RES},
      '{CMD_EXEC, CH_CLOSE, 16'h0200, 1'b0, NO_RES},
      '{CMD_EXEC, CH_MINUS, 16'h0201, 1'b0, NO_RES},
      '{CMD_EXEC, CH_CLOSE, 16'h0202, 1'b0, NO_RES},
      // skip over a nested body on a zero cell
      '{CMD_EXEC, CH_OPEN,  16'h0300, 1'b0, NO_RES},
      '{CMD_EXEC, CH_PLUS,  16'h0301, 1'b0, NO_RES},
      '{CMD_EXEC, CH_OPEN,  16'h0302, 1'b0, NO_RES},
      '{CMD_EXEC, CH_CLOSE, 16'h0303, 1'b0, NO_RES},
      '{CMD_EXEC, CH_CLOSE, 16'h0304, 1'b0, NO_RES},
      // bytes that are not instructions
      '{CMD_EXEC, 8'h2C,    16'h8000, 1'b0, NO_RES},
      '{CMD_EXEC, 8'hFF,    16'hFFFE, 1'b0, NO_RES},
      '{CMD_EXEC, 8'h00,    16'h7FFF, 1'b0, NO_RES},
      // start: every result field is zero
      '{CMD_START, CH_PLUS, 16'hFFFF, 1'b1, '{16'h0000, 1'b0, 8'h00, 1'b0, ERR_NONE}},
      '{CMD_EXEC, CH_DOT,   16'h5555, 1'b0, NO_RES},
      '{CMD_EXEC, CH_OPEN,  16'hAAAA, 1'b0, NO_RES},
      // start while skipping drops skip mode
      '{CMD_START, CH_CLOSE, 16'h1357, 1'b1, '{16'h0000, 1'b0, 8'h00, 1'b0, ERR_NONE}}
    };
  end

  // ---------------------------------------------------------------------------
  // request generation
  // ---------------------------------------------------------------------------
  phase_e      phase = PH_TABLE;
  int          tab_idx = 0;
  gen_mode_e   gmode = GM_NOISE;
  int          gm_left = 0;
  bit          start_pending = 1'b0;
  bit          prog_begin = 1'b0;
  logic [7:0]  prog_q [$];
  logic [15:0] prog_base = 16'h0000;
  logic [15:0] pc = 16'h0000;
  logic [15:0] seq_addr = 16'h0000;
  int          starts_left = 10;
  int          idle_pct = 20;
  int          req_gap = 0;
  int          rand_count = 0;
  bit          tail_entered = 1'b0;
  int          tail_opens = 0;
  int          tail_closes = 0;
  bit          cur_typed = 1'b0;
  res_t        cur_want = '0;

  always @(posedge clk) begin : drive_requests
    res_t        pred;
    logic        nc;
    logic [7:0]  nb;
    logic [15:0] na;
    logic [15:0] off;
    bit          got;
    int          pick, roll, depth, len;
    if (!rst_n) begin
      cmd_valid <= 1'b0;
    end else begin
      // accepted request: mirror it and queue what must come back
      if (cmd_valid && !cmd_stall_o) begin
        pred = execute_step(command, code_byte, code_address);
        pc = pred.nxt;
        expected_q.push_back(cur_typed ? cur_want : pred);
        if (phase == PH_RANDOM && (command == CMD_START || code_byte inside
            {CH_PLUS, CH_MINUS, CH_LT, CH_GT, CH_OPEN, CH_CLOSE, CH_DOT}))
          rand_count++;
      end

      // request slot is free: idle, or present the next one
      if (!cmd_valid || !cmd_stall_o) begin
        if (phase == PH_TABLE && tab_idx == DIR_N) phase = PH_RANDOM;
        if (phase == PH_RANDOM && rand_count >= RAND_ITEMS) phase = PH_TAIL;
        if (phase == PH_TAIL && tail_closes == TAIL_CLOSES) phase = PH_DONE;

        if (phase == PH_DONE) begin
          cmd_valid <= 1'b0;
        end else if (req_gap > 0) begin
          req_gap--;
          cmd_valid <= 1'b0;
        end else if (phase != PH_TAIL && $urandom_range(0, 99) < idle_pct) begin
          // idle burst, its remaining length held in req_gap
          req_gap = $urandom_range(0, 10);
          cmd_valid <= 1'b0;
        end else begin
          nc = CMD_EXEC;
          nb = CH_DOT;
          na = 16'($urandom());
          cur_typed = 1'b0;
          case (phase)
            PH_TABLE: begin
              nc = dir_tab[tab_idx].cmd;
              nb = dir_tab[tab_idx].b;
              na = dir_tab[tab_idx].a;
              cur_typed = dir_tab[tab_idx].typed;
              cur_want = dir_tab[tab_idx].want;
              tab_idx++;
            end
            PH_RANDOM: begin
              got = 1'b0;
              while (!got) begin
                if (gm_left == 0) begin
                  // new stretch: pick its kind and its idling
                  pick = $urandom_range(0, 99);
                  roll = $urandom_range(0, 2);
                  idle_pct = (roll == 0) ? 0 : ((roll == 1) ? 8 : 30);
                  seq_addr = 16'($urandom());
                  if (pick < 60) begin
                    // small program, brackets balanced but for random bytes,
                    // run by following the predicted fetch address
                    gmode = GM_PROG;
                    prog_q.delete();
                    depth = 0;
                    len = $urandom_range(8, 40);
                    prog_base = ($urandom_range(0, 7) == 0) ?
                                16'hFFFF - 16'($urandom_range(0, 20)) : 16'($urandom());
                    repeat ($urandom_range(0, 3)) prog_q.push_back(CH_PLUS);
                    for (int i = 0; i < len; i++) begin
                      roll = $urandom_range(0, 99);
                      if (roll < 12) begin
                        prog_q.push_back(CH_OPEN);
                        depth++;
                      end else if (roll < 26 && depth > 0) begin
                        prog_q.push_back(CH_CLOSE);
                        depth--;
                      end else if (roll < 30) begin
                        // clear-cell idiom
                        prog_q.push_back(CH_OPEN);
                        prog_q.push_back(CH_MINUS);
                        prog_q.push_back(CH_CLOSE);
                      end else if (roll < 33) begin
                        prog_q.push_back(8'($urandom()));
                      end else begin
                        prog_q.push_back(OP_CHARS[$urandom_range(0, 4)]);
                      end
                    end
                    while (depth > 0) begin
                      prog_q.push_back(CH_CLOSE);
                      depth--;
                    end
                    gm_left = $urandom_range(20, 120);
                    prog_begin = 1'b1;
                    start_pending = (starts_left > 0 && $urandom_range(0, 5) == 0);
                    if (start_pending) starts_left--;
                  end else if (pick < 72) begin
                    // fill the return stack past its top
                    gmode = GM_PUSH;
                    gm_left = STACK_N - ret_count + $urandom_range(1, 4);
                  end else if (pick < 84) begin
                    // drain the return stack past empty
                    gmode = GM_POP;
                    gm_left = ret_count + $urandom_range(1, 3);
                  end else begin
                    gmode = GM_NOISE;
                    gm_left = $urandom_range(5, 30);
                  end
                end

                case (gmode)
                  GM_PROG: begin
                    if (start_pending) begin
                      nc = CMD_START;
                      nb = 8'($urandom());
                      start_pending = 1'b0;
                      got = 1'b1;
                    end else begin
                      if (prog_begin) begin
                        pc = prog_base;
                        prog_begin = 1'b0;
                      end
                      off = pc - prog_base;
                      if (off >= prog_q.size()) begin
                        gm_left = 0;
                      end else begin
                        nb = prog_q[off];
                        na = pc;
                        gm_left--;
                        got = 1'b1;
                      end
                    end
                  end
                  GM_PUSH: begin
                    na = seq_addr;
                    seq_addr++;
                    if (skip_on) nb = CH_CLOSE;
                    else if (tape_mem[dptr] == 8'h00) nb = CH_PLUS;
                    else begin
                      nb = CH_OPEN;
                      gm_left--;
                    end
                    got = 1'b1;
                  end
                  GM_POP: begin
                    na = seq_addr;
                    seq_addr++;
                    if (skip_on) nb = CH_CLOSE;
                    else if (tape_mem[dptr] != 8'h00) nb = CH_GT;
                    else begin
                      nb = CH_CLOSE;
                      gm_left--;
                    end
                    got = 1'b1;
                  end
                  default: begin
                    nb = $urandom_range(0, 1) ? 8'($urandom()) :
                         OP_CHARS[$urandom_range(0, 6)];
                    if (starts_left > 0 && $urandom_range(0, 99) == 0) begin
                      nc = CMD_START;
                      starts_left--;
                    end
                    gm_left--;
                    got = 1'b1;
                  end
                endcase
              end
            end
            default: begin
              // closing stretch, back to back with no idling on either side
              na = seq_addr;
              seq_addr++;
              if (!tail_entered) begin
                if (skip_on) nb = CH_CLOSE;
                else if (tape_mem[dptr] != 8'h00) nb = CH_GT;
                else begin
                  nb = CH_OPEN;
                  tail_entered = 1'b1;
                end
              end else if (tail_opens < TAIL_OPENS) begin
                nb = CH_OPEN;
                tail_opens++;
              end else begin
                nb = CH_CLOSE;
                tail_closes++;
              end
            end
          endcase
          cmd_valid <= 1'b1;
          command <= nc;
          code_byte <= nb;
          code_address <= na;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result checking and result-side stalls
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  int stall_pct = 10;
  int stall_epoch = 0;

  always @(posedge clk) begin : check_results
    res_t want;
    int   roll;
    if (rst_n) begin
      if (res_valid_o && !res_stall) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result with no request pending: next=%h out=%b/%h skip=%b err=%0d",
                     $realtime, next_address_o, out_valid_o, out_byte_o, skipping_o, error_o);
        end else begin
          want = expected_q.pop_front();
          if (next_address_o !== want.nxt || out_valid_o !== want.ov ||
              out_byte_o !== want.ob || skipping_o !== want.sk || error_o !== want.er) begin
            fail_count++;
            if (fail_count <= 10) begin
              $write("%0t: mismatch: want next=%h out=%b/%h skip=%b err=%0d, ",
                     $realtime, want.nxt, want.ov, want.ob, want.sk, want.er);
              $display("got next=%h out=%b/%h skip=%b err=%0d",
                       next_address_o, out_valid_o, out_byte_o, skipping_o, error_o);
            end
          end
        end
      end

      // stall bursts counted down in stall_left; stall_epoch paces stall_pct
      if (phase == PH_TAIL || phase == PH_DONE) begin
        res_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, 10);
        res_stall <= 1'b1;
      end else begin
        res_stall <= 1'b0;
      end
      stall_epoch++;
      if (stall_epoch % 256 == 0) begin
        roll = $urandom_range(0, 2);
        stall_pct = (roll == 0) ? 0 : ((roll == 1) ? 10 : 35);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // reset, end of run
  // ---------------------------------------------------------------------------
  initial begin : run_control
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // all requests taken and every result back
    while (phase != PH_DONE || cmd_valid || expected_q.size() != 0) @(posedge clk);
    // let any stray result show up
    repeat (40) @(posedge clk);
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("bf_instruction_executor_unit test passed");
    end else begin
      $display("bf_instruction_executor_unit test failed");
    end
    $finish;
  end

  // watchdog: covers the clearing passes after reset and after each start
  initial begin : watchdog
    int n;
    n = 0;
    while (n < CYCLE_LIMIT) begin
      @(posedge clk);
      n++;
    end
    $display("bf_instruction_executor_unit test failed");
    $finish;
  end

endmodule

@@ bf_instruction_executor_unit.f @@
hw/rtl/bfx_pkg.sv
hw/rtl/bfx_front.sv
hw/rtl/bfx_back.sv
hw/rtl/bf_instruction_executor_unit.sv
hw/rtl/bfx_checker.sv
tb/tb.sv
